// File: sv/indexed_list_engine_macros.svh
// Assertion macros used by the checker file.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ILE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds.
`define ILE_ASSERT_NEVER(name, cond, msg) \
	`ILE_ASSERT(name, !(cond), msg)

`endif

// File: sv/ile_pkg.sv
package ile_pkg;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 7;
	localparam int OP_W    = 2;
	localparam int ST_W    = 2;
	localparam int IN_W    = OP_W + POS_W + DATA_W;
	localparam int OUT_W   = DATA_W + ST_W + POS_W;
	localparam int TDATA_W = 48;
	localparam int GROUP   = 8;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_DONE = 2'd2
	} state_t;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] pos;
	} cell_cmd_t;

endpackage

// File: sv/ile_cell.sv
module ile_cell #(
	parameter int INDEX = 0
) (
	input  logic                       clk,
	input  ile_pkg::cell_cmd_t         cmd,
	input  logic [ile_pkg::DATA_W-1:0] ins_value,
	input  logic [ile_pkg::DATA_W-1:0] left_data,
	input  logic [ile_pkg::DATA_W-1:0] right_data,
	output logic [ile_pkg::DATA_W-1:0] data,
	output logic [ile_pkg::DATA_W-1:0] rd_data
);

	localparam int            PW   = ile_pkg::POS_W;
	localparam logic [PW-1:0] IDX  = PW'(INDEX);
	localparam bit            HIGH = (INDEX >= (1 << PW));

	logic [ile_pkg::DATA_W-1:0] data_q;
	logic                       is_eq;
	logic                       is_gt;

	assign is_eq = !HIGH && (cmd.pos == IDX);
	assign is_gt = HIGH || (IDX > cmd.pos);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (is_eq) begin
				data_q <= ins_value;
			end else if (is_gt) begin
				data_q <= left_data;
			end
		end else if (cmd.del && (is_eq || is_gt)) begin
			data_q <= right_data;
		end
	end

	assign data    = data_q;
	assign rd_data = is_eq ? data_q : '0;

endmodule

// File: sv/indexed_list_engine.sv
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells. Each item
// reads, inserts or deletes at a position and returns one result with the read value, a
// status (done, out of range, full) and the entry count after the item. The block takes
// one item at a time: an item passes the EXEC state, where insert and delete shift all
// cells at once and the addressed cell is gathered into registered groups, then the DONE
// state, where the final OR loads the output register once it is empty or m_tready takes
// the previous result; the block then returns to IDLE for the next item. Entry contents
// are not cleared by reset; only entries below the count are ever read.
module indexed_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// operation [1:0], list_position [8:2], item_value [40:9], zero [47:41]
	input  logic [ile_pkg::TDATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// read_value [31:0], status [33:32], entry_count [40:34], zero [47:41]
	output logic [ile_pkg::TDATA_W-1:0] m_tdata
);

	localparam int DW = ile_pkg::DATA_W;
	localparam int PW = ile_pkg::POS_W;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > PW) ? CW : PW;
	localparam int NG = (CAPACITY + ile_pkg::GROUP - 1) / ile_pkg::GROUP;

	ile_pkg::state_t    state_q, state_d;
	logic [CW-1:0]      count_q;
	logic               m_tvalid_q;
	logic               load_out;

	ile_pkg::op_t       op_q;
	logic [PW-1:0]      pos_q;
	logic signed [DW-1:0] val_q;

	ile_pkg::cell_cmd_t cmd;
	logic [DW-1:0]      cell_data [CAPACITY];
	logic [DW-1:0]      cell_rd   [CAPACITY];
	logic [DW-1:0]      grp_d     [NG];
	logic [DW-1:0]      grp_s1    [NG];
	logic [DW-1:0]      tree_or;

	logic [MW-1:0]      pos_ext;
	logic [MW-1:0]      cnt_ext;
	logic               full;
	ile_pkg::status_t   status_d;
	ile_pkg::status_t   status_s1;
	logic               rd_ok_d, rd_bad_d;
	logic               rd_ok_s1, rd_bad_s1;
	logic               do_ins, do_del;
	logic [DW-1:0]      rd_value;
	logic [ile_pkg::OUT_W-1:0] m_data_q;

	assign pos_ext = MW'(pos_q);
	assign cnt_ext = MW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));

	always_comb begin
		status_d = ile_pkg::ST_DONE;
		rd_ok_d  = 1'b0;
		rd_bad_d = 1'b0;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		case (op_q)
			ile_pkg::OP_READ: begin
				if (pos_ext < cnt_ext) begin
					rd_ok_d = 1'b1;
				end else begin
					rd_bad_d = 1'b1;
					status_d = ile_pkg::ST_RANGE;
				end
			end
			ile_pkg::OP_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_d = ile_pkg::ST_RANGE;
				end else if (full) begin
					status_d = ile_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			ile_pkg::OP_DELETE: begin
				if (pos_ext >= cnt_ext) begin
					status_d = ile_pkg::ST_RANGE;
				end else begin
					do_del = 1'b1;
				end
			end
			default: begin
				status_d = ile_pkg::ST_RANGE;
			end
		endcase
	end

	assign cmd.ins = (state_q == ile_pkg::S_EXEC) && do_ins;
	assign cmd.del = (state_q == ile_pkg::S_EXEC) && do_del;
	assign cmd.pos = pos_q;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DW-1:0] left_data;
		logic [DW-1:0] right_data;
		if (g == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_left
			assign left_data = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_right
			assign right_data = cell_data[g+1];
		end
		ile_cell #(
			.INDEX(g)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.ins_value (val_q),
			.left_data (left_data),
			.right_data(right_data),
			.data      (cell_data[g]),
			.rd_data   (cell_rd[g])
		);
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < ile_pkg::GROUP; k++) begin
				if (g * ile_pkg::GROUP + k < CAPACITY) begin
					grp_d[g] = grp_d[g] | cell_rd[g * ile_pkg::GROUP + k];
				end
			end
		end
	end

	always_comb begin
		tree_or = '0;
		for (int g = 0; g < NG; g++) begin
			tree_or = tree_or | grp_s1[g];
		end
	end

	assign rd_value = rd_ok_s1 ? tree_or : (rd_bad_s1 ? '1 : '0);

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		s_tready = 1'b0;
		case (state_q)
			ile_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ile_pkg::S_EXEC;
				end
			end
			ile_pkg::S_EXEC: begin
				state_d = ile_pkg::S_DONE;
			end
			ile_pkg::S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ile_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ile_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ile_pkg::S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ins) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.del) begin
				count_q <= count_q - CW'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= ile_pkg::op_t'(s_tdata[ile_pkg::OP_W-1:0]);
			pos_q <= s_tdata[ile_pkg::OP_W +: PW];
			val_q <= s_tdata[ile_pkg::OP_W + PW +: DW];
		end
		if (state_q == ile_pkg::S_EXEC) begin
			grp_s1    <= grp_d;
			status_s1 <= status_d;
			rd_ok_s1  <= rd_ok_d;
			rd_bad_s1 <= rd_bad_d;
		end
		if (load_out) begin
			m_data_q <= {cnt_ext[PW-1:0], status_s1, rd_value};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(ile_pkg::TDATA_W - ile_pkg::OUT_W)'(0), m_data_q};

endmodule

// File: sv/ile_checker.sv
`include "indexed_list_engine_macros.svh"

module ile_checker #(
	parameter int CAPACITY = 64
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [ile_pkg::TDATA_W-1:0] s_tdata,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [ile_pkg::TDATA_W-1:0] m_tdata
);

	localparam logic [ile_pkg::POS_W-1:0] CAP7 = ile_pkg::POS_W'(CAPACITY);

	logic               in_acc;
	ile_pkg::status_t   st;
	logic [ile_pkg::POS_W-1:0] cnt;
	logic [ile_pkg::DATA_W-1:0] rdv;

	assign in_acc = s_tvalid && s_tready;
	assign rdv    = m_tdata[ile_pkg::DATA_W-1:0];
	assign st     = ile_pkg::status_t'(m_tdata[ile_pkg::DATA_W +: ile_pkg::ST_W]);
	assign cnt    = m_tdata[ile_pkg::DATA_W + ile_pkg::ST_W +: ile_pkg::POS_W];

	`ILE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	`ILE_ASSERT(a_one_at_a_time, in_acc |=> !s_tready, "item accepted while another is at work")
	`ILE_ASSERT(a_full_count, m_tvalid && st == ile_pkg::ST_FULL |-> cnt == CAP7 && rdv == '0, "full status with wrong count or value")
	`ILE_ASSERT_NEVER(a_bad_status, m_tvalid && m_tdata[ile_pkg::DATA_W +: ile_pkg::ST_W] == 2'd3, "undefined status code")

endmodule

bind indexed_list_engine ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (.*);

// File: bench/indexed_list_engine_tb.sv
`timescale 1ns / 100ps

module indexed_list_engine_tb;
	import ile_pkg::*;

	localparam int CAPACITY = 64;
	localparam int ITEM_TOTAL = 1550;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [OP_W-1:0] op;
		logic [POS_W-1:0] pos;
		logic [DATA_W-1:0] value;
	} list_req_t;

	typedef struct {
		logic [DATA_W-1:0] read_value;
		status_t status;
		logic [POS_W-1:0] entry_count;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;

	list_req_t pending_reqs[$];
	list_result_t expected_results[$];
	list_req_t cur_req;

	logic [DATA_W-1:0] list_cells [0:CAPACITY-1];
	int list_len = 0;
	int gen_len = 0;

	int accepted_items = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int phase;
	int send_idle_pct;
	int recv_stall_pct;

	indexed_list_engine #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// apply one request to the shadow list and return its result
	function automatic list_result_t apply_list_request(list_req_t req);
		list_result_t res;
		int p;
		res.read_value = '0;
		res.status = ST_DONE;
		p = req.pos;
		case (req.op)
			OP_READ: begin
				if (p < list_len) begin
					res.read_value = list_cells[p];
				end else begin
					res.read_value = '1;
					res.status = ST_RANGE;
				end
			end
			OP_INSERT: begin
				if (p > list_len) begin
					res.status = ST_RANGE;
				end else if (list_len >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (int i = list_len; i > p; i--)
						list_cells[i] = list_cells[i-1];
					list_cells[p] = req.value;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (p >= list_len) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = p; i + 1 < list_len; i++)
						list_cells[i] = list_cells[i+1];
					list_len--;
				end
			end
			default: begin
				res.status = ST_RANGE;
			end
		endcase
		res.entry_count = list_len[POS_W-1:0];
		return res;
	endfunction

	// queue a request and track the length it leaves behind
	function automatic void queue_request(logic [OP_W-1:0] op, int pos, logic [DATA_W-1:0] value);
		list_req_t req;
		req.op = op;
		req.pos = pos[POS_W-1:0];
		req.value = value;
		if (op == OP_INSERT && req.pos <= gen_len && gen_len < CAPACITY)
			gen_len++;
		else if (op == OP_DELETE && req.pos < gen_len)
			gen_len--;
		pending_reqs.push_back(req);
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_insert_pos();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return gen_len;
			default: return $urandom_range(0, gen_len);
		endcase
	endfunction

	function automatic int pick_entry_pos();
		if (gen_len == 0)
			return 0;
		case ($urandom_range(0, 3))
			0: return 0;
			1: return gen_len - 1;
			default: return $urandom_range(0, gen_len - 1);
		endcase
	endfunction

	task automatic note_mismatch(input string field, input logic [DATA_W-1:0] exp_v,
			input logic [DATA_W-1:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s expected 0x%08h, got 0x%08h", $time, field, exp_v, act_v);
	endtask

	initial begin
		int seg;
		int seg_len;
		int roll;

		queue_request(OP_READ, 0, 32'h0);
		queue_request(OP_DELETE, 0, 32'h0);
		queue_request(OP_INSERT, 1, 32'h1234_5678);
		queue_request(OP_UNUSED, 127, 32'hFFFF_FFFF);
		queue_request(OP_INSERT, 0, 32'h7FFF_FFFF);
		queue_request(OP_INSERT, 1, 32'h8000_0000);
		queue_request(OP_INSERT, 0, 32'hFFFF_FFFF);
		queue_request(OP_INSERT, 3, 32'h0000_0000);
		queue_request(OP_INSERT, 2, 32'h5A5A_A5A5);
		queue_request(OP_READ, 0, 32'h0);
		queue_request(OP_READ, 1, 32'h0);
		queue_request(OP_READ, 2, 32'h0);
		queue_request(OP_READ, 3, 32'h0);
		queue_request(OP_READ, 4, 32'h0);
		queue_request(OP_READ, 5, 32'h0);
		queue_request(OP_READ, 127, 32'hFFFF_FFFF);
		queue_request(OP_DELETE, 127, 32'h0);
		queue_request(OP_INSERT, 7, 32'hDEAD_BEEF);
		queue_request(OP_DELETE, 2, 32'h0);
		queue_request(OP_DELETE, 3, 32'h0);
		queue_request(OP_DELETE, 0, 32'h0);
		queue_request(OP_READ, 0, 32'h0);
		queue_request(OP_READ, 1, 32'h0);
		queue_request(OP_UNUSED, 0, 32'h0);

		// repeat segments that grow toward full, churn, then drain toward empty
		seg = 0;
		while (pending_reqs.size() < ITEM_TOTAL) begin
			seg_len = $urandom_range(60, 120);
			for (int n = 0; n < seg_len; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					queue_request(OP_W'($urandom_range(0, 3)), $urandom_range(0, 127),
						$urandom);
				end else if (roll < 9) begin
					queue_request(OP_W'($urandom_range(0, 2)), gen_len + $urandom_range(0, 2),
						pick_value());
				end else begin
					roll = $urandom_range(0, 99);
					case (seg % 3)
						0: begin
							if (roll < 75)
								queue_request(OP_INSERT, pick_insert_pos(), pick_value());
							else if (roll < 92)
								queue_request(OP_READ, pick_entry_pos(), pick_value());
							else
								queue_request(OP_DELETE, pick_entry_pos(), pick_value());
						end
						1: begin
							if (roll < 35)
								queue_request(OP_INSERT, pick_insert_pos(), pick_value());
							else if (roll < 70)
								queue_request(OP_READ, pick_entry_pos(), pick_value());
							else
								queue_request(OP_DELETE, pick_entry_pos(), pick_value());
						end
						default: begin
							if (roll < 10)
								queue_request(OP_INSERT, pick_insert_pos(), pick_value());
							else if (roll < 30)
								queue_request(OP_READ, pick_entry_pos(), pick_value());
							else
								queue_request(OP_DELETE, pick_entry_pos(), pick_value());
						end
					endcase
				end
			end
			seg++;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (!(pending_reqs.size() == 0 && !s_tvalid && expected_results.size() == 0)
				&& idle_cycles < STALL_LIMIT)
			@(posedge clk);
		if (idle_cycles < STALL_LIMIT)
			repeat (DRAIN_CYCLES) @(posedge clk);

		if (idle_cycles < STALL_LIMIT && mismatches == 0 && expected_results.size() == 0)
			$display("indexed_list_engine verification clean");
		else
			$display("indexed_list_engine verification failed");
		$finish;
	end

	always_comb begin
		phase = (accepted_items >> 7) & 3;
		case (phase)
			1: send_idle_pct = 61;
			3: send_idle_pct = 29;
			default: send_idle_pct = 0;
		endcase
		case (phase)
			2: recv_stall_pct = 61;
			3: recv_stall_pct = 29;
			default: recv_stall_pct = 0;
		endcase
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_list_request(cur_req));
				accepted_items <= accepted_items + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(TDATA_W - IN_W){1'b0}}, cur_req.value, cur_req.pos, cur_req.op};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		list_result_t exp_res;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected item", '0, m_tdata[DATA_W-1:0]);
				end else begin
					exp_res = expected_results.pop_front();
					if (m_tdata[31:0] !== exp_res.read_value)
						note_mismatch("read_value", exp_res.read_value, m_tdata[31:0]);
					if (m_tdata[33:32] !== exp_res.status)
						note_mismatch("status", exp_res.status, m_tdata[33:32]);
					if (m_tdata[40:34] !== exp_res.entry_count)
						note_mismatch("entry_count", exp_res.entry_count, m_tdata[40:34]);
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

// File: files.f
+incdir+sv
sv/ile_pkg.sv
sv/ile_cell.sv
sv/indexed_list_engine.sv
sv/ile_checker.sv
bench/indexed_list_engine_tb.sv
